[rtl/assert_macros.svh]
// assert_macros.svh: assertion shorthands shared by the RTL files.
// Depends on nothing; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every edge outside reset.
`define ASSERT_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked in the cycle after its trigger, outside reset.
`define ASSERT_NEXT(label, clk, rst, trig, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (prop)) else $error(msg);

`endif

[rtl/isd_pkg.sv]
// isd_pkg: types and constants of the indent style detector.
// No dependencies; imported by the detector top level.
`timescale 1ns / 1ps
`default_nettype none

package isd_pkg;

   // Character codes examined by the line scanner
   localparam logic [7:0] CH_NL     = 8'd10;
   localparam logic [7:0] CH_TAB    = 8'd9;
   localparam logic [7:0] CH_SPACE  = 8'd32;
   localparam logic [7:0] CH_HASH   = 8'd35;
   localparam logic [7:0] CH_STAR   = 8'd42;
   localparam logic [7:0] CH_SLASH  = 8'd47;
   localparam logic [7:0] CH_BSLASH = 8'd92;

   localparam logic [7:0] COUNT_MAX   = 8'hFF;
   localparam logic [7:0] LONG_SPACES = 8'd8;
   localparam int         TAB_SHIFT   = 3;

   localparam logic [1:0] STYLE_SPACES = 2'd0;
   localparam logic [1:0] STYLE_TABS   = 2'd1;
   localparam logic [1:0] STYLE_MIXED  = 2'd2;
   localparam logic [3:0] DEFAULT_WIDTH = 4'd4;

   typedef enum logic [2:0] {
      CL_NOIND = 3'd0,
      CL_LONG  = 3'd1,
      CL_TAB   = 3'd2,
      CL_MIXED = 3'd3,
      CL_SHORT = 3'd4,
      CL_IGN   = 3'd5
   } class_type;

   typedef enum logic [3:0] {
      PH_START = 4'b0001,
      PH_WS    = 4'b0010,
      PH_SLASH = 4'b0100,
      PH_REST  = 4'b1000
   } phase_type;

   typedef enum logic [3:0] {
      ST_RUN   = 4'b0001,
      ST_SCAN  = 4'b0010,
      ST_DRAIN = 4'b0100,
      ST_EMIT  = 4'b1000
   } state_type;

   typedef struct packed {
      phase_type  phase;
      class_type  cls;
      logic [7:0] spc;
      logic [7:0] tabs;
   } line_type;

endpackage

`default_nettype wire

[rtl/isd_if.sv]
// isd_if: valid/ready channels of the indent style detector.
// isd_req_if carries text bytes, isd_rsp_if carries the detected style.
`timescale 1ns / 1ps
`default_nettype none

interface isd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       last_byte;

   modport source (output valid, output text_byte, output last_byte, input ready);
   modport sink   (input valid, input text_byte, input last_byte, output ready);
endinterface

interface isd_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] indent_style;
   logic [3:0] indent_width;

   modport source (output valid, output indent_style, output indent_width, input ready);
   modport sink   (input valid, input indent_style, input indent_width, output ready);
endinterface

`default_nettype wire

[rtl/indent_style_detector.sv]
// indent_style_detector: finds the indentation style of a text stream.
// Depends on isd_pkg, isd_if.sv and assert_macros.svh.
// Usage: req_chan takes one text byte per item with last_byte marking the
// final byte of a text. rsp_chan gives one item per text: indent_style
// (0 spaces, 1 tabs, 2 mixed) and indent_width in columns.
// Throughput: one byte per cycle while a text streams in. Line-pair step
// counts live in a small synchronous RAM, one entry per step value holding
// the space and the mixed count; each line end that counts a step reads
// its entry and writes it back incremented on the next cycle, with
// read-during-write bypass. After the last byte the block scans the RAM,
// one entry per cycle, and zeroes each entry behind the scan; req_chan
// stays not ready until the result has been loaded for output. Bytes of
// the next text are taken while the result waits in its output register;
// a stalled receiver only holds the block at the end of the following
// text.
// Reset (synchronous) clears the line state, the tab score, the output
// valid and the per-entry valid bits of the RAM.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module indent_style_detector
   import isd_pkg::*;
#(
   parameter int MAX_STEP   = 8,
   parameter int SCORE_BITS = 20
) (
   input  wire         clock,
   input  wire         reset,
   isd_req_if.sink     req_chan,
   isd_rsp_if.source   rsp_chan
);

   localparam int NBINS  = MAX_STEP - 1;
   localparam int BIN_AW = $clog2(NBINS);
   localparam int SB     = SCORE_BITS;
   localparam int WW     = SCORE_BITS + 4;

   typedef logic [SB-1:0] score_type;

   // ---------------------------------------------------------------- functions
   function automatic class_type classify(line_type s);
      class_type c;
      if (s.tabs != 8'd0 && s.spc != 8'd0)
         c = (s.spc >= LONG_SPACES) ? CL_IGN : CL_MIXED;
      else if (s.tabs != 8'd0)
         c = CL_TAB;
      else
         c = (s.spc < LONG_SPACES) ? CL_SHORT : CL_LONG;
      return c;
   endfunction

   function automatic line_type count_blank(line_type s, logic [7:0] b);
      line_type r;
      r = s;
      if (b == CH_SPACE && s.spc != COUNT_MAX)
         r.spc = s.spc + 8'd1;
      if (b == CH_TAB && s.tabs != COUNT_MAX)
         r.tabs = s.tabs + 8'd1;
      return r;
   endfunction

   function automatic line_type feed_fn(line_type s, logic cont, logic [7:0] b);
      line_type r;
      logic     blank;
      r     = s;
      blank = (b == CH_SPACE) || (b == CH_TAB);
      unique case (s.phase)
         PH_START: begin
            if (cont) begin
               r.phase = PH_REST;
            end else if (b == CH_NL) begin
               r.cls = CL_IGN;
            end else if (!blank) begin
               r.cls   = CL_NOIND;
               r.spc   = 8'd0;
               r.tabs  = 8'd0;
               r.phase = PH_REST;
            end else begin
               r.spc   = 8'd0;
               r.tabs  = 8'd0;
               r       = count_blank(r, b);
               r.phase = PH_WS;
            end
         end
         PH_WS: begin
            if (blank) begin
               r = count_blank(s, b);
            end else if (b == CH_STAR || b == CH_HASH || b == CH_NL) begin
               r.cls   = CL_IGN;
               r.phase = PH_REST;
            end else if (b == CH_SLASH) begin
               r.phase = PH_SLASH;
            end else begin
               r.cls   = classify(s);
               r.phase = PH_REST;
            end
         end
         PH_SLASH: begin
            r.cls   = (b == CH_STAR) ? CL_IGN : classify(s);
            r.phase = PH_REST;
         end
         PH_REST: r = s;
         default: r = s;
      endcase
      return r;
   endfunction

   function automatic logic step_ok(logic signed [12:0] d);
      return (d >= 13'sd2) && (d <= 13'(MAX_STEP));
   endfunction

   function automatic score_type sat_inc(score_type v);
      return (v == '1) ? v : v + score_type'(1);
   endfunction

   // 10 * v > 11 * n is the same test as v > floor(11n / 10)
   function automatic logic beats(score_type v, score_type n);
      logic [WW-1:0] vx, nx, lhs, rhs;
      vx  = WW'(v);
      nx  = WW'(n);
      lhs = (vx << 3) + (vx << 1);
      rhs = (nx << 3) + (nx << 1) + nx;
      return lhs > rhs;
   endfunction

   // ---------------------------------------------------------------- registers
   state_type          state_ff;
   line_type           line_ff;
   class_type          prev_cls_ff;
   logic [7:0]         prev_spc_ff, prev_tabs_ff;
   logic               bs_ff, cont_ff;
   score_type          tab_ff;

   logic [2*SB-1:0]    bin_mem [NBINS];
   logic [NBINS-1:0]   bin_vld_ff;
   logic [2*SB-1:0]    rd_data_ff;

   logic               upd_valid_ff, upd_space_ff, upd_mixed_ff;
   logic [BIN_AW-1:0]  upd_addr_ff;

   logic [BIN_AW-1:0]  scan_addr_ff, scan_proc_addr_ff;
   logic               scan_pend_ff;
   score_type          smax_ff, mmax_ff, best_s_ff, best_m_ff;
   logic [3:0]         width_s_ff, width_m_ff;
   logic               found_s_ff, found_m_ff;

   logic               rsp_valid_ff;
   logic [1:0]         style_ff;
   logic [3:0]         width_ff;

   // ---------------------------------------------------------------- byte path
   logic               accept, is_nl, line_end;
   line_type           line_fed, line_in;
   class_type          cls_end;

   assign accept   = req_chan.valid && req_chan.ready;
   assign is_nl    = (req_chan.text_byte == CH_NL);
   assign line_end = accept && (is_nl || req_chan.last_byte);
   assign line_fed = feed_fn(line_ff, cont_ff, req_chan.text_byte);

   // A final byte that is not a newline closes its line as a newline would
   always_comb begin
      cls_end = line_fed.cls;
      if (!is_nl) begin
         if (line_fed.phase == PH_WS)
            cls_end = CL_IGN;
         else if (line_fed.phase == PH_SLASH)
            cls_end = classify(line_fed);
      end
   end

   always_comb begin
      line_in = line_fed;
      if (is_nl) begin
         line_in.phase = PH_START;
      end
   end

   // ---------------------------------------------------------------- pair rules
   logic signed [12:0] cs, ct, ps, pt, d_sp, d_tm, d_mt, bin_d;
   logic               pr_tab, pr_space, pr_mixed;
   logic [BIN_AW-1:0]  pair_addr;

   always_comb begin
      cs   = $signed({5'd0, line_fed.spc});
      ct   = $signed({5'd0, line_fed.tabs});
      ps   = $signed({5'd0, prev_spc_ff});
      pt   = $signed({5'd0, prev_tabs_ff});
      d_sp = cs - ps;
      d_tm = (ct <<< TAB_SHIFT) - ps;
      d_mt = (13'sd1 <<< TAB_SHIFT) - ps;
      pr_tab   = 1'b0;
      pr_space = 1'b0;
      pr_mixed = 1'b0;
      bin_d    = d_sp;
      priority if (cls_end == CL_TAB && (prev_cls_ff == CL_TAB || prev_cls_ff == CL_NOIND)) begin
         pr_tab = (ct - pt == 13'sd1);
      end else if (cls_end == CL_NOIND && (prev_cls_ff == CL_LONG
                   || prev_cls_ff == CL_SHORT || prev_cls_ff == CL_NOIND)) begin
         pr_space = step_ok(d_sp);
      end else if (cls_end == CL_SHORT && (prev_cls_ff == CL_SHORT
                   || prev_cls_ff == CL_NOIND)) begin
         pr_space = step_ok(d_sp);
         pr_mixed = step_ok(d_sp);
      end else if (prev_cls_ff == CL_SHORT && cls_end == CL_TAB) begin
         bin_d    = d_tm;
         pr_mixed = step_ok(d_tm);
      end else if (prev_cls_ff == CL_TAB && cls_end == CL_MIXED) begin
         bin_d    = cs;
         pr_mixed = (pt == ct) && step_ok(cs);
      end else if (prev_cls_ff == CL_MIXED && cls_end == CL_TAB) begin
         bin_d    = d_mt;
         pr_mixed = (pt + 13'sd1 == ct) && step_ok(d_mt);
      end else begin
         pr_tab = 1'b0;
      end
   end

   assign pair_addr = BIN_AW'(bin_d - 13'sd2);

   // ---------------------------------------------------------------- step RAM
   logic               wr_en;
   logic [BIN_AW-1:0]  wr_addr, rd_addr;
   logic [2*SB-1:0]    wr_data;
   score_type          old_s, old_m;

   assign old_s   = rd_data_ff[SB-1:0];
   assign old_m   = rd_data_ff[2*SB-1:SB];
   assign wr_en   = upd_valid_ff || scan_pend_ff;
   assign wr_addr = upd_valid_ff ? upd_addr_ff : scan_proc_addr_ff;
   assign wr_data = upd_valid_ff
                    ? {(upd_mixed_ff ? sat_inc(old_m) : old_m),
                       (upd_space_ff ? sat_inc(old_s) : old_s)}
                    : '0;
   assign rd_addr = (state_ff == ST_SCAN) ? scan_addr_ff : pair_addr;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         bin_mem[wr_addr] <= wr_data;
      end
      // bypass a write to the entry being read; unwritten entries read as zero
      if (wr_en && wr_addr == rd_addr)
         rd_data_ff <= wr_data;
      else if (bin_vld_ff[rd_addr])
         rd_data_ff <= bin_mem[rd_addr];
      else
         rd_data_ff <= '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bin_vld_ff <= '0;
      end else if (wr_en) begin
         bin_vld_ff[wr_addr] <= 1'b1;
      end
   end

   // ---------------------------------------------------------------- scan
   logic [3:0]         step_now;
   logic               s_beats, m_beats;
   logic [1:0]         style_in;
   logic [3:0]         width_in;
   logic               rsp_load;

   assign step_now = 4'(32'(scan_proc_addr_ff) + 32'd2);
   assign s_beats  = beats(old_s, best_s_ff);
   assign m_beats  = beats(old_m, best_m_ff);

   always_comb begin
      style_in = STYLE_SPACES;
      width_in = DEFAULT_WIDTH;
      priority if (smax_ff >= mmax_ff && smax_ff > tab_ff) begin
         if (found_s_ff)
            width_in = width_s_ff;
      end else if (tab_ff > mmax_ff && tab_ff > smax_ff) begin
         style_in = STYLE_TABS;
      end else if (mmax_ff >= tab_ff && mmax_ff > smax_ff) begin
         if (found_m_ff) begin
            style_in = STYLE_MIXED;
            width_in = width_m_ff;
         end
      end else begin
         style_in = STYLE_SPACES;
      end
   end

   assign rsp_load = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_chan.ready);

   // ---------------------------------------------------------------- control
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_RUN;
         line_ff       <= '{phase: PH_START, cls: CL_IGN, spc: 8'd0, tabs: 8'd0};
         prev_cls_ff   <= CL_IGN;
         prev_spc_ff   <= 8'd0;
         prev_tabs_ff  <= 8'd0;
         bs_ff         <= 1'b0;
         cont_ff       <= 1'b0;
         tab_ff        <= '0;
         upd_valid_ff  <= 1'b0;
         scan_pend_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         upd_valid_ff <= line_end && (pr_space || pr_mixed);
         scan_pend_ff <= (state_ff == ST_SCAN);

         if (accept) begin
            bs_ff <= (req_chan.text_byte == CH_BSLASH);
            if (line_end && pr_tab)
               tab_ff <= sat_inc(tab_ff);
            if (req_chan.last_byte) begin
               // the text is done: restart line tracking for the next one
               line_ff      <= '{phase: PH_START, cls: CL_IGN, spc: 8'd0, tabs: 8'd0};
               prev_cls_ff  <= CL_IGN;
               prev_spc_ff  <= 8'd0;
               prev_tabs_ff <= 8'd0;
               bs_ff        <= 1'b0;
               cont_ff      <= 1'b0;
               state_ff     <= ST_SCAN;
            end else begin
               line_ff <= line_in;
               if (is_nl) begin
                  prev_cls_ff  <= cls_end;
                  prev_spc_ff  <= line_fed.spc;
                  prev_tabs_ff <= line_fed.tabs;
                  cont_ff      <= bs_ff;
               end
            end
         end

         unique case (state_ff)
            ST_RUN:   ;
            ST_SCAN:  if (scan_addr_ff == '0) state_ff <= ST_DRAIN;
            ST_DRAIN: state_ff <= ST_EMIT;
            ST_EMIT: begin
               if (rsp_load) begin
                  tab_ff   <= '0;
                  state_ff <= ST_RUN;
               end
            end
            default:  state_ff <= ST_RUN;
         endcase

         if (rsp_load)
            rsp_valid_ff <= 1'b1;
         else if (rsp_chan.ready)
            rsp_valid_ff <= 1'b0;
      end
   end

   // payload registers of the update, the scan and the response
   always_ff @(posedge clock) begin
      upd_addr_ff       <= pair_addr;
      upd_space_ff      <= pr_space;
      upd_mixed_ff      <= pr_mixed;
      scan_proc_addr_ff <= scan_addr_ff;

      if (accept && req_chan.last_byte) begin
         scan_addr_ff <= BIN_AW'(NBINS - 1);
         smax_ff      <= '0;
         mmax_ff      <= '0;
         best_s_ff    <= '0;
         best_m_ff    <= '0;
         width_s_ff   <= DEFAULT_WIDTH;
         width_m_ff   <= DEFAULT_WIDTH;
         found_s_ff   <= 1'b0;
         found_m_ff   <= 1'b0;
      end else if (state_ff == ST_SCAN && scan_addr_ff != '0) begin
         scan_addr_ff <= scan_addr_ff - BIN_AW'(1);
      end

      // steps arrive from the widest down; a narrower one must lead by over 10%
      if (scan_pend_ff) begin
         if (old_s > smax_ff) smax_ff <= old_s;
         if (old_m > mmax_ff) mmax_ff <= old_m;
         if (s_beats) begin
            best_s_ff  <= old_s;
            width_s_ff <= step_now;
            found_s_ff <= 1'b1;
         end
         if (m_beats) begin
            best_m_ff  <= old_m;
            width_m_ff <= step_now;
            found_m_ff <= 1'b1;
         end
      end

      if (rsp_load) begin
         style_ff <= style_in;
         width_ff <= width_in;
      end
   end

   assign req_chan.ready        = (state_ff == ST_RUN);
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.indent_style = style_ff;
   assign rsp_chan.indent_width = width_ff;

   // ---------------------------------------------------------------- checks
   `ASSERT_RST(a_one_writer, clock, reset,
      !(upd_valid_ff && scan_pend_ff), "RAM write port clash")
   `ASSERT_NEXT(a_last_scans, clock, reset, accept && req_chan.last_byte,
      state_ff == ST_SCAN, "last item did not start scan")
   `ASSERT_RST(a_scan_data, clock, reset,
      scan_pend_ff |-> (state_ff == ST_SCAN || state_ff == ST_DRAIN),
      "scan data outside scan")
   `ASSERT_RST(a_rsp_source, clock, reset,
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_EMIT), "result raised outside emit")

endmodule

`default_nettype wire
